@@ rtl/core/reverse_common_substring_suffix_array_core_defines.svh @@
// assertion macros for the reverse common substring core checker
// expects clk and arst_n in the scope where a macro is used
`ifndef REVERSE_COMMON_SUBSTRING_SUFFIX_ARRAY_CORE_DEFINES_SVH
`define REVERSE_COMMON_SUBSTRING_SUFFIX_ARRAY_CORE_DEFINES_SVH

// same-cycle implication
`define RCSS_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rcss check failed");

// next-cycle implication
`define RCSS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rcss check failed");

`endif

@@ rtl/core/rcss_pkg.sv @@
// shared types and constants of the reverse common substring core
// no dependencies
`default_nettype none

package rcss_pkg;

	localparam int MAX_LEN_DEF = 1024;
	localparam int LEVELS_DEF  = 12;
	localparam logic [7:0] SEP_CHAR = 8'd35;

	localparam int START_W  = 12;
	localparam int LEN_W    = 11;
	localparam int S_DATA_W = 8;
	localparam int M_DATA_W = 24;

	typedef enum logic [4:0] {
		OP_IDLE, OP_LOAD, OP_SEP, OP_MIR_RD, OP_MIR_WR, OP_LVL, OP_CLR,
		OP_PFX_RD, OP_PFX_WR, OP_E_SRC, OP_E_HI, OP_E_LO, OP_E_KEY, OP_E_BKT,
		OP_E_RNK, OP_NEXT_LVL, OP_L_INIT, OP_L_FIRST, OP_L_RDB, OP_L_B,
		OP_L_RX, OP_L_RY, OP_L_CMP, OP_L_END, OP_OUT
	} op_t;

	typedef enum logic [1:0] {PASS_LO, PASS_HI, PASS_RANK} pass_t;

	typedef enum logic [4:0] {
		S_LOAD, S_SEP, S_MIR_RD, S_MIR_WR, S_LVL, S_CLR, S_PFX_RD, S_PFX_WR,
		S_E_SRC, S_E_HI, S_E_LO, S_E_KEY, S_E_BKT, S_E_RNK, S_NEXT_LVL,
		S_L_INIT, S_L_FIRST, S_L_RDB, S_L_B, S_L_TEST, S_L_RX, S_L_RY,
		S_L_CMP, S_L_END, S_DONE
	} state_t;

	typedef struct packed {
		op_t   op;
		pass_t pass;
		logic  scatter;
		logic  i_clr;
	} cmd_t;

	typedef struct packed {
		logic i_last;
		logic sweep_last;
		logic mir_last;
		logic more_lvl;
		logic k_go;
		logic out_busy;
	} stat_t;

endpackage

`default_nettype wire

@@ rtl/core/rcss_ctrl.sv @@
// sequencer of the reverse common substring core
// depends on rcss_pkg; drives the datapath through cmd_t, reads stat_t
`default_nettype none

module rcss_ctrl (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             s_tvalid,
	input  wire             s_tlast,
	input  rcss_pkg::stat_t stat,
	output logic            s_tready,
	output rcss_pkg::cmd_t  cmd
);
	import rcss_pkg::*;

	state_t state_q, state_n;
	pass_t  pass_q, pass_n;
	logic   scat_q, scat_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			pass_q  <= PASS_LO;
			scat_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			pass_q  <= pass_n;
			scat_q  <= scat_n;
		end
	end

	always_comb begin
		state_n     = state_q;
		pass_n      = pass_q;
		scat_n      = scat_q;
		s_tready    = 1'b0;
		cmd.op      = OP_IDLE;
		cmd.pass    = pass_q;
		cmd.scatter = scat_q;
		cmd.i_clr   = 1'b0;
		unique case (state_q)
			S_LOAD: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.op = OP_LOAD;
					if (s_tlast)
						state_n = S_SEP;
				end
			end
			S_SEP: begin
				cmd.op  = OP_SEP;
				state_n = S_MIR_RD;
			end
			S_MIR_RD: begin
				cmd.op  = OP_MIR_RD;
				state_n = S_MIR_WR;
			end
			S_MIR_WR: begin
				cmd.op  = OP_MIR_WR;
				state_n = stat.mir_last ? S_LVL : S_MIR_RD;
			end
			S_LVL: begin
				cmd.op    = OP_LVL;
				cmd.i_clr = 1'b1;
				if (stat.more_lvl) begin
					pass_n  = PASS_LO;
					scat_n  = 1'b0;
					state_n = S_CLR;
				end else begin
					state_n = S_L_INIT;
				end
			end
			S_CLR: begin
				cmd.op = OP_CLR;
				if (stat.sweep_last) begin
					cmd.i_clr = 1'b1;
					state_n   = S_E_SRC;
				end
			end
			S_PFX_RD: begin
				cmd.op  = OP_PFX_RD;
				state_n = S_PFX_WR;
			end
			S_PFX_WR: begin
				cmd.op = OP_PFX_WR;
				if (stat.sweep_last) begin
					cmd.i_clr = 1'b1;
					scat_n    = 1'b1;
					state_n   = S_E_SRC;
				end else begin
					state_n = S_PFX_RD;
				end
			end
			S_E_SRC: begin
				cmd.op  = OP_E_SRC;
				state_n = S_E_HI;
			end
			S_E_HI: begin
				cmd.op  = OP_E_HI;
				state_n = S_E_LO;
			end
			S_E_LO: begin
				cmd.op  = OP_E_LO;
				state_n = (pass_q == PASS_RANK) ? S_E_RNK : S_E_KEY;
			end
			S_E_KEY: begin
				cmd.op  = OP_E_KEY;
				state_n = S_E_BKT;
			end
			S_E_BKT: begin
				cmd.op = OP_E_BKT;
				if (stat.i_last) begin
					cmd.i_clr = 1'b1;
					if (!scat_q) begin
						state_n = S_PFX_RD;
					end else if (pass_q == PASS_LO) begin
						pass_n  = PASS_HI;
						scat_n  = 1'b0;
						state_n = S_CLR;
					end else begin
						pass_n  = PASS_RANK;
						state_n = S_E_SRC;
					end
				end else begin
					state_n = S_E_SRC;
				end
			end
			S_E_RNK: begin
				cmd.op = OP_E_RNK;
				if (stat.i_last) begin
					cmd.i_clr = 1'b1;
					state_n   = S_NEXT_LVL;
				end else begin
					state_n = S_E_SRC;
				end
			end
			S_NEXT_LVL: begin
				cmd.op  = OP_NEXT_LVL;
				state_n = S_LVL;
			end
			S_L_INIT: begin
				cmd.op  = OP_L_INIT;
				state_n = S_L_FIRST;
			end
			S_L_FIRST: begin
				cmd.op  = OP_L_FIRST;
				state_n = S_L_RDB;
			end
			S_L_RDB: begin
				cmd.op  = OP_L_RDB;
				state_n = S_L_B;
			end
			S_L_B: begin
				cmd.op  = OP_L_B;
				state_n = S_L_TEST;
			end
			S_L_TEST: begin
				state_n = stat.k_go ? S_L_RX : S_L_END;
			end
			S_L_RX: begin
				cmd.op  = OP_L_RX;
				state_n = S_L_RY;
			end
			S_L_RY: begin
				cmd.op  = OP_L_RY;
				state_n = S_L_CMP;
			end
			S_L_CMP: begin
				cmd.op  = OP_L_CMP;
				state_n = S_L_TEST;
			end
			S_L_END: begin
				cmd.op  = OP_L_END;
				state_n = stat.i_last ? S_DONE : S_L_RDB;
			end
			S_DONE: begin
				if (!stat.out_busy) begin
					cmd.op  = OP_OUT;
					state_n = S_LOAD;
				end
			end
			default: state_n = S_LOAD;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/core/rcss_dp.sv @@
// datapath of the reverse common substring core: rank levels, sort buffers,
// bucket counts, lcp scan and output register; depends on rcss_pkg
`default_nettype none

module rcss_dp #(
	parameter int MAX_LEN = rcss_pkg::MAX_LEN_DEF,
	parameter int LEVELS  = rcss_pkg::LEVELS_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  rcss_pkg::cmd_t                  cmd,
	output rcss_pkg::stat_t                 stat,
	input  wire  [rcss_pkg::S_DATA_W-1:0]   s_tdata,
	output logic                            m_tvalid,
	input  wire                             m_tready,
	output logic [rcss_pkg::M_DATA_W-1:0]   m_tdata
);
	import rcss_pkg::*;

	localparam int TEXT_MAX = 2 * MAX_LEN + 1;
	localparam int KEY_SPAN = TEXT_MAX + 258;
	localparam int IW       = $clog2(TEXT_MAX + 1);
	localparam int NW       = $clog2(MAX_LEN + 1);
	localparam int KW       = $clog2(KEY_SPAN);
	localparam int RW       = (IW > 8) ? IW : 8;
	localparam int CW       = (IW > KW) ? IW : KW;
	localparam int LVW      = $clog2(LEVELS + 1);
	localparam int LAW      = $clog2(LEVELS);
	localparam int SW       = ((IW > LEVELS) ? IW : LEVELS) + 1;
	localparam int RDEPTH   = LEVELS * (2 ** IW);

	// memories
	logic [RW-1:0] rank_mem [RDEPTH];
	logic [IW-1:0] tmp_mem  [TEXT_MAX];
	logic [IW-1:0] sa_mem   [TEXT_MAX];
	logic [IW-1:0] bkt_mem  [KEY_SPAN];

	logic              rk_we;
	logic [LAW+IW-1:0] rk_waddr, rk_raddr;
	logic [RW-1:0]     rk_wdata, rk_rd;
	logic              tmp_we, sa_we;
	logic [IW-1:0]     sc_addr, sa_raddr, tmp_rd, sa_rd;
	logic              bk_we;
	logic [KW-1:0]     bk_waddr, bk_raddr;
	logic [IW-1:0]     bk_wdata, bk_rd;

	// control registers
	logic [NW-1:0]  cnt_q;
	logic [CW-1:0]  i_q;
	logic [LVW-1:0] lvl_q;
	logic           out_valid_q;

	// payload registers
	logic [IW-1:0]      total_q, p_q, sum_q, a_q, b_q, where_q;
	logic [RW-1:0]      hi_q, prv_hi_q, prv_rank_q, rx_q;
	logic               inr_q;
	logic [KW-1:0]      key_q, prv_lo_q;
	logic [SW-1:0]      x_q, y_q, ret_q, best_q;
	logic [LVW-1:0]     k_q;
	logic [START_W-1:0] out_start_q;
	logic [LEN_W-1:0]   out_len_q;

	logic [IW-1:0]  i_iw, cnt_iw, p_c, src_rd;
	logic [KW-1:0]  i_kw, lo_c, key_c;
	logic [LVW-1:0] lvl_m1, k_m1;
	logic [SW-1:0]  step, pst, half, k_inc, total_sw;
	logic [RW-1:0]  r_c;
	logic           eq_c, cross_c;

	assign i_iw     = i_q[IW-1:0];
	assign i_kw     = i_q[KW-1:0];
	assign cnt_iw   = IW'(cnt_q);
	assign lvl_m1   = lvl_q - LVW'(1);
	assign k_m1     = k_q - LVW'(1);
	assign total_sw = SW'(total_q);
	assign step     = SW'(1) << lvl_m1;
	assign k_inc    = SW'(1) << k_q;
	assign half     = (lvl_q < LVW'(2)) ? '0 : (SW'(1) << (lvl_q - LVW'(2)));
	assign src_rd   = (cmd.pass == PASS_HI) ? tmp_rd : sa_rd;
	assign p_c      = (cmd.pass == PASS_LO) ? i_iw : src_rd;
	assign pst      = SW'(p_q) + step;
	// a suffix past the end sorts below every rank
	assign lo_c     = inr_q ? (KW'(rk_rd) + KW'(1)) : '0;
	assign key_c    = (cmd.pass == PASS_LO) ? lo_c : KW'(hi_q);
	assign eq_c     = (i_q != '0) && (hi_q == prv_hi_q) && (lo_c == prv_lo_q);
	assign r_c      = eq_c ? prv_rank_q : RW'(i_iw);
	assign cross_c  = ((a_q < cnt_iw) && (b_q > cnt_iw)) ||
		((b_q < cnt_iw) && (a_q > cnt_iw));

	// rank memory ports
	always_comb begin
		rk_we    = 1'b0;
		rk_waddr = '0;
		rk_wdata = '0;
		case (cmd.op)
			OP_LOAD: begin
				rk_we    = (cnt_q < NW'(MAX_LEN));
				rk_waddr = {LAW'(0), cnt_iw};
				rk_wdata = RW'(s_tdata);
			end
			OP_SEP: begin
				rk_we    = 1'b1;
				rk_waddr = {LAW'(0), cnt_iw};
				rk_wdata = RW'(SEP_CHAR);
			end
			OP_MIR_WR: begin
				rk_we    = 1'b1;
				rk_waddr = {LAW'(0), cnt_iw + IW'(1) + i_iw};
				rk_wdata = rk_rd;
			end
			OP_E_RNK: begin
				rk_we    = 1'b1;
				rk_waddr = {LAW'(lvl_q), p_q};
				rk_wdata = r_c;
			end
			default: ;
		endcase
	end

	always_comb begin
		case (cmd.op)
			OP_MIR_RD: rk_raddr = {LAW'(0), cnt_iw - IW'(1) - i_iw};
			OP_E_HI:   rk_raddr = {LAW'(lvl_m1), p_c};
			OP_E_LO:   rk_raddr = {LAW'(lvl_m1), pst[IW-1:0]};
			OP_L_RX:   rk_raddr = {LAW'(k_m1), x_q[IW-1:0]};
			OP_L_RY:   rk_raddr = {LAW'(k_q), y_q[IW-1:0]};
			default:   rk_raddr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rk_we)
			rank_mem[rk_waddr] <= rk_wdata;
		rk_rd <= rank_mem[rk_raddr];
	end

	// sort buffers
	assign sc_addr  = bk_rd;
	assign tmp_we   = (cmd.op == OP_E_BKT) && cmd.scatter && (cmd.pass == PASS_LO);
	assign sa_we    = (cmd.op == OP_E_BKT) && cmd.scatter && (cmd.pass == PASS_HI);
	assign sa_raddr = (cmd.op == OP_L_INIT) ? '0 : i_iw;

	always_ff @(posedge clk) begin
		if (tmp_we)
			tmp_mem[sc_addr] <= p_q;
		tmp_rd <= tmp_mem[i_iw];
	end

	always_ff @(posedge clk) begin
		if (sa_we)
			sa_mem[sc_addr] <= p_q;
		sa_rd <= sa_mem[sa_raddr];
	end

	// bucket counts
	always_comb begin
		bk_we    = 1'b0;
		bk_waddr = i_kw;
		bk_wdata = '0;
		case (cmd.op)
			OP_CLR: bk_we = 1'b1;
			OP_PFX_WR: begin
				bk_we    = 1'b1;
				bk_wdata = sum_q;
			end
			OP_E_BKT: begin
				bk_we    = 1'b1;
				bk_waddr = key_q;
				bk_wdata = bk_rd + IW'(1);
			end
			default: ;
		endcase
	end

	assign bk_raddr = (cmd.op == OP_E_KEY) ? key_c : i_kw;

	always_ff @(posedge clk) begin
		if (bk_we)
			bkt_mem[bk_waddr] <= bk_wdata;
		bk_rd <= bkt_mem[bk_raddr];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			i_q         <= '0;
			lvl_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_LOAD && cnt_q < NW'(MAX_LEN))
				cnt_q <= cnt_q + NW'(1);
			else if (cmd.op == OP_OUT)
				cnt_q <= '0;

			if (cmd.i_clr)
				i_q <= '0;
			else begin
				case (cmd.op)
					OP_SEP:    i_q <= '0;
					OP_L_INIT: i_q <= CW'(1);
					OP_MIR_WR, OP_CLR, OP_PFX_WR, OP_E_BKT, OP_E_RNK, OP_L_END:
						i_q <= i_q + CW'(1);
					default: ;
				endcase
			end

			if (cmd.op == OP_SEP)
				lvl_q <= LVW'(1);
			else if (cmd.op == OP_NEXT_LVL)
				lvl_q <= lvl_q + LVW'(1);

			if (cmd.op == OP_OUT)
				out_valid_q <= 1'b1;
			else if (out_valid_q && m_tready)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_SEP:    total_q <= IW'({cnt_q, 1'b1});
			OP_CLR:    sum_q <= '0;
			OP_PFX_WR: sum_q <= sum_q + bk_rd;
			OP_E_HI:   p_q <= p_c;
			OP_E_LO: begin
				hi_q  <= rk_rd;
				inr_q <= (pst < total_sw);
			end
			OP_E_KEY:  key_q <= key_c;
			OP_E_RNK: begin
				prv_hi_q   <= hi_q;
				prv_lo_q   <= lo_c;
				prv_rank_q <= r_c;
			end
			OP_L_INIT: begin
				best_q  <= '0;
				where_q <= '0;
			end
			OP_L_FIRST: a_q <= sa_rd;
			OP_L_B: begin
				b_q   <= sa_rd;
				x_q   <= SW'(a_q);
				y_q   <= SW'(sa_rd);
				k_q   <= lvl_q;
				ret_q <= '0;
			end
			OP_L_RX: k_q  <= k_m1;
			OP_L_RY: rx_q <= rk_rd;
			OP_L_CMP: begin
				if (rx_q == rk_rd) begin
					x_q   <= x_q + k_inc;
					y_q   <= y_q + k_inc;
					ret_q <= ret_q + k_inc;
				end
			end
			OP_L_END: begin
				// strict compare keeps the first winner in suffix order
				if (ret_q > best_q && cross_c) begin
					best_q  <= ret_q;
					where_q <= b_q;
				end
				a_q <= b_q;
			end
			OP_OUT: begin
				out_start_q <= START_W'(where_q);
				out_len_q   <= LEN_W'(best_q);
			end
			default: ;
		endcase
	end

	assign stat.i_last     = (i_q == CW'(total_q - IW'(1)));
	assign stat.sweep_last = (i_q == CW'(KEY_SPAN - 1));
	assign stat.mir_last   = (i_q == CW'(cnt_q) - CW'(1));
	assign stat.more_lvl   = (half < total_sw) && (lvl_q < LVW'(LEVELS));
	assign stat.k_go       = (k_q != '0) && (x_q < total_sw) && (y_q < total_sw);
	assign stat.out_busy   = out_valid_q;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_DATA_W'({out_len_q, out_start_q});

endmodule

`default_nettype wire

@@ rtl/core/reverse_common_substring_suffix_array_core.sv @@
// Longest common substring of a string and its reverse via suffix array.
// Input stream s_*: one string byte per transfer, s_tlast on the final byte.
// Bytes past MAX_LEN are dropped; a dropped byte with s_tlast still ends it.
// Output stream m_*: one transfer per string, start in the merged text
// (string, separator, reversed string) and length of the match.
// Loading keeps s_tready high, so every valid byte is taken. After the last
// byte, s_tready stays low while the block builds the merged text of N = 2n+1
// bytes from n string bytes, then runs up to LEVELS-1 doubling levels, with
// K = 2*MAX_LEN+259 bucket entries swept by the counting sorts over the
// bucket memory, then the lcp scan over neighbor pairs, paced by the rank
// memory read port.
// The result sits in an output register; a new string may load while it
// waits, and the next result waits until m_tready takes the previous one.
// Reset empties the string and the output register; memories are not cleared.
// Implemented as rcss_ctrl (sequencer) and rcss_dp (memories, lcp scan).
`default_nettype none

module reverse_common_substring_suffix_array_core #(
	parameter int MAX_LEN = rcss_pkg::MAX_LEN_DEF,
	parameter int LEVELS  = rcss_pkg::LEVELS_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           s_tvalid,
	output logic                          s_tready,
	input  wire  [rcss_pkg::S_DATA_W-1:0] s_tdata,   // [7:0] char_in
	input  wire                           s_tlast,   // is_last
	output logic                          m_tvalid,
	input  wire                           m_tready,
	output logic [rcss_pkg::M_DATA_W-1:0] m_tdata    // [11:0] match_start, [22:12] match_length
);
	import rcss_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	rcss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.stat     (stat),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	rcss_dp #(
		.MAX_LEN (MAX_LEN),
		.LEVELS  (LEVELS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire

@@ rtl/core/rcss_chk.sv @@
// port-level checker for the reverse common substring core, bound to the top
// depends on rcss_pkg and the assertion macro header
`default_nettype none
`include "reverse_common_substring_suffix_array_core_defines.svh"

module rcss_chk (
	input wire                           clk,
	input wire                           arst_n,
	input wire                           s_tvalid,
	input wire                           s_tready,
	input wire [rcss_pkg::S_DATA_W-1:0]  s_tdata,
	input wire                           s_tlast,
	input wire                           m_tvalid,
	input wire                           m_tready,
	input wire [rcss_pkg::M_DATA_W-1:0]  m_tdata
);
	// held result stays put
	`RCSS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	// the final byte closes the input until the result is built
	`RCSS_ASSERT_NEXT(a_last_stops_input, s_tvalid && s_tready && s_tlast, !s_tready)
	// a result appears only from the compute phase
	`RCSS_ASSERT_IMPL(a_result_after_compute, $rose(m_tvalid), !$past(s_tready))
	// no match reports start zero
	`RCSS_ASSERT_IMPL(a_empty_match, m_tvalid && m_tdata[22:12] == 11'd0, m_tdata[11:0] == 12'd0)

endmodule

bind reverse_common_substring_suffix_array_core rcss_chk u_rcss_chk (.*);

`default_nettype wire

@@ tb/testbench.sv @@
// stream testbench for reverse_common_substring_suffix_array_core
// depends on rcss_pkg and the core rtl; self-checking against a built-in suffix array model
`timescale 1ns / 100ps
`default_nettype none

module testbench;

	localparam int MAX_LEN  = rcss_pkg::MAX_LEN_DEF;
	localparam int LEVELS   = rcss_pkg::LEVELS_DEF;
	localparam int TEXT_MAX = 2 * MAX_LEN + 1;
	localparam int KEY_SPAN = TEXT_MAX + 258;
	localparam longint CYCLE_LIMIT = 80_000_000;
	localparam int HOLD_CYCLES = 300_000;
	localparam int HOLD_AT = 12;
	localparam int RANDOM_ITEMS = 1500;

	typedef struct packed {
		logic [rcss_pkg::LEN_W-1:0]   length;
		logic [rcss_pkg::START_W-1:0] start;
	} match_t;

	typedef struct {
		logic [7:0] ch;
		logic       last;
		bit         typed;
		int         exp_start;
		int         exp_len;
	} row_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [rcss_pkg::S_DATA_W-1:0] s_tdata;
	logic s_tlast;
	logic m_tvalid;
	logic m_tready;
	logic [rcss_pkg::M_DATA_W-1:0] m_tdata;

	reverse_common_substring_suffix_array_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	match_t pending_matches[$];
	int     errors;
	longint cycles;

	// model state
	logic [7:0] text_bytes[TEXT_MAX];
	int         stored_chars;
	int         rank_by_level[LEVELS][TEXT_MAX];
	int         sa_order[TEXT_MAX];
	int         sa_scratch[TEXT_MAX];
	int         key_first[TEXT_MAX];
	int         key_second[TEXT_MAX];
	int         bucket_base[KEY_SPAN];
	int         built_levels;

	// stable counting sort; from_scratch picks direction and key
	function automatic void counting_pass(input bit from_scratch, input int total);
		int i, sum, c, idx, k;
		for (i = 0; i < KEY_SPAN; i++) bucket_base[i] = 0;
		for (i = 0; i < total; i++) begin
			idx = from_scratch ? sa_scratch[i] : sa_order[i];
			k = from_scratch ? key_second[idx] : key_first[idx];
			bucket_base[k]++;
		end
		sum = 0;
		for (i = 0; i < KEY_SPAN; i++) begin
			c = bucket_base[i];
			bucket_base[i] = sum;
			sum += c;
		end
		for (i = 0; i < total; i++) begin
			idx = from_scratch ? sa_scratch[i] : sa_order[i];
			k = from_scratch ? key_second[idx] : key_first[idx];
			if (from_scratch) sa_order[bucket_base[k]] = idx;
			else sa_scratch[bucket_base[k]] = idx;
			bucket_base[k]++;
		end
	endfunction

	function automatic int shared_prefix(input int x, input int y, input int total);
		int k, len;
		k = built_levels > LEVELS ? LEVELS : built_levels;
		len = 0;
		while (k > 0 && x < total && y < total) begin
			k--;
			if (rank_by_level[k][x] == rank_by_level[k][y]) begin
				x += 1 << k;
				y += 1 << k;
				len += 1 << k;
			end
		end
		return len;
	endfunction

	function automatic match_t find_mirror_match();
		int n, total, i, j, lvl, span, p, q, a, b, c, best, where;
		match_t m;
		n = stored_chars;
		total = 2 * n + 1;
		text_bytes[n] = rcss_pkg::SEP_CHAR;
		for (i = 0; i < n; i++) text_bytes[n + 1 + i] = text_bytes[n - 1 - i];
		for (i = 0; i < total; i++) begin
			rank_by_level[0][i] = text_bytes[i];
			sa_order[i] = i;
		end
		lvl = 1;
		span = 1;
		while ((span >> 1) < total && lvl < LEVELS) begin
			for (i = 0; i < total; i++) begin
				key_first[i] = rank_by_level[lvl-1][i];
				key_second[i] = (i + span < total) ? rank_by_level[lvl-1][i+span] + 1 : 0;
				sa_scratch[i] = i;
			end
			counting_pass(1'b1, total);
			counting_pass(1'b0, total);
			for (i = 0; i < total; i++) sa_order[i] = sa_scratch[i];
			for (j = 0; j < total; j++) begin
				p = sa_order[j];
				rank_by_level[lvl][p] = j;
				if (j > 0) begin
					q = sa_order[j-1];
					if (key_first[p] == key_first[q] && key_second[p] == key_second[q])
						rank_by_level[lvl][p] = rank_by_level[lvl][q];
				end
			end
			lvl++;
			span <<= 1;
		end
		built_levels = lvl;
		best = 0;
		where = 0;
		for (j = 1; j < total; j++) begin
			a = sa_order[j-1];
			b = sa_order[j];
			c = shared_prefix(a, b, total);
			if (c > best && ((a < n && b > n) || (b < n && a > n))) begin
				best = c;
				where = b;
			end
		end
		m.start = rcss_pkg::START_W'(where);
		m.length = rcss_pkg::LEN_W'(best);
		return m;
	endfunction

	// returns 1 when the byte closes a string and a match is due
	function automatic bit absorb_char(input logic [7:0] ch, input logic last, output match_t m);
		m = '0;
		if (stored_chars < MAX_LEN) begin
			text_bytes[stored_chars] = ch;
			stored_chars++;
		end
		if (!last) return 0;
		m = find_mirror_match();
		stored_chars = 0;
		return 1;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("reverse_common_substring_suffix_array_core verification failed");
				$finish;
			end
		end
	end

	// one transfer; idle gap first, then wait for the handshake
	task automatic send_char(input logic [7:0] ch, input logic last, input bit typed,
			input int exp_start, input int exp_len);
		int gap;
		bit due;
		bit ready_seen;
		match_t m;
		gap = $urandom_range(0, 6);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= ch;
		s_tlast <= last;
		// tready is sampled mid-cycle, where it holds its value for the coming edge
		do begin
			@(negedge clk);
			ready_seen = s_tready;
			@(posedge clk);
		end while (!ready_seen);
		due = absorb_char(ch, last, m);
		if (due) begin
			if (typed) begin
				m.start = rcss_pkg::START_W'(exp_start);
				m.length = rcss_pkg::LEN_W'(exp_len);
			end
			pending_matches.push_back(m);
		end
	endtask

	task automatic drain_matches();
		s_tvalid <= 1'b0;
		while (pending_matches.size() != 0) @(posedge clk);
	endtask

	task automatic send_string(input int len, input int flavor);
		logic [7:0] str[$];
		logic [7:0] ch;
		int i, half;
		str = {};
		for (i = 0; i < len; i++) begin
			case (flavor)
				0: ch = 8'($urandom_range(0, 255));
				1: ch = 8'(8'h61 + $urandom_range(0, 2));
				2: ch = ($urandom_range(0, 4) == 0) ? rcss_pkg::SEP_CHAR :
					8'(8'h61 + $urandom_range(0, 3));
				default: ch = 8'(8'h61 + $urandom_range(0, 1));
			endcase
			str.push_back(ch);
		end
		// plant a palindrome in the middle
		if (flavor == 3 && len > 4) begin
			half = len / 2;
			for (i = 0; i < half / 2; i++) str[half + i] = str[half - 1 - i];
		end
		for (i = 0; i < len; i++) send_char(str[i], i == len - 1, 1'b0, 0, 0);
	endtask

	// receiver: random stall per result, one long hold-off to back the block up
	initial begin
		int stall, taken;
		bit seen;
		match_t got, want;
		m_tready = 1'b0;
		taken = 0;
		@(posedge arst_n);
		forever begin
			if (taken == HOLD_AT) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				stall = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 6);
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			// tvalid and tdata are sampled mid-cycle, ahead of the accepting edge
			do begin
				@(negedge clk);
				seen = m_tvalid;
				got = m_tdata[rcss_pkg::START_W + rcss_pkg::LEN_W - 1:0];
				@(posedge clk);
			end while (!seen);
			taken++;
			if (pending_matches.size() == 0) begin
				$error("unexpected result transfer: match_start %0d match_length %0d",
					got.start, got.length);
				errors++;
			end else begin
				want = pending_matches.pop_front();
				if (got.start !== want.start) begin
					$error("match_start expected %0d actual %0d", want.start, got.start);
					errors++;
				end
				if (got.length !== want.length) begin
					$error("match_length expected %0d actual %0d", want.length, got.length);
					errors++;
				end
				if (m_tdata[rcss_pkg::M_DATA_W-1:rcss_pkg::START_W + rcss_pkg::LEN_W] !== '0) begin
					$error("m_tdata pad expected 0 actual %0h",
						m_tdata[rcss_pkg::M_DATA_W-1:rcss_pkg::START_W + rcss_pkg::LEN_W]);
					errors++;
				end
			end
		end
	end

	initial begin
		row_t rows[$];
		int i, sent, len, flavor, strings;
		errors = 0;
		stored_chars = 0;
		built_levels = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single bytes mirror onto themselves: match at 0, length 1
		rows.push_back('{8'h61, 1'b1, 1'b1, 0, 1});
		rows.push_back('{8'h00, 1'b1, 1'b1, 0, 1});
		rows.push_back('{8'hFF, 1'b1, 1'b1, 0, 1});
		// a lone separator byte: every neighbor pair touches the middle, no match
		rows.push_back('{8'h23, 1'b1, 1'b1, 0, 0});
		rows.push_back('{8'hFF, 1'b0, 1'b0, 0, 0});
		rows.push_back('{8'h00, 1'b0, 1'b0, 0, 0});
		rows.push_back('{8'hFF, 1'b1, 1'b0, 0, 0});
		// separator inside the string
		rows.push_back('{8'h23, 1'b0, 1'b0, 0, 0});
		rows.push_back('{8'h23, 1'b0, 1'b0, 0, 0});
		rows.push_back('{8'h61, 1'b1, 1'b0, 0, 0});
		// racecar-like
		rows.push_back('{8'h61, 1'b0, 1'b0, 0, 0});
		rows.push_back('{8'h62, 1'b0, 1'b0, 0, 0});
		rows.push_back('{8'h61, 1'b0, 1'b0, 0, 0});
		rows.push_back('{8'h63, 1'b1, 1'b0, 0, 0});
		// repeated byte: ties between many suffix pairs
		rows.push_back('{8'h55, 1'b0, 1'b0, 0, 0});
		rows.push_back('{8'h55, 1'b0, 1'b0, 0, 0});
		rows.push_back('{8'h55, 1'b0, 1'b0, 0, 0});
		rows.push_back('{8'h55, 1'b1, 1'b0, 0, 0});
		// distinct bytes: the string shares only single bytes with its mirror
		rows.push_back('{8'h01, 1'b0, 1'b0, 0, 0});
		rows.push_back('{8'h80, 1'b1, 1'b0, 0, 0});
		foreach (rows[i])
			send_char(rows[i].ch, rows[i].last, rows[i].typed, rows[i].exp_start,
				rows[i].exp_len);
		drain_matches();

		sent = 0;
		strings = 0;
		while (sent < RANDOM_ITEMS) begin
			flavor = $urandom_range(0, 3);
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(9, 90);
			// one string past the length limit, last byte among the dropped ones
			if (strings == 5) len = MAX_LEN + 6;
			send_string(len, flavor);
			sent += len;
			strings++;
			if (strings == 20) drain_matches();
		end
		drain_matches();
		s_tlast <= 1'b0;
		repeat (2000) @(posedge clk);
		if (errors == 0 && pending_matches.size() == 0) begin
			$display("reverse_common_substring_suffix_array_core verification clean");
		end else begin
			$display("reverse_common_substring_suffix_array_core verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
